### design/ccah_pkg.sv
// ----------------------------------------------------------------------------
// ccah_pkg
// Types and constants shared by the command acknowledge handler modules.
// ----------------------------------------------------------------------------
package ccah_pkg;

  localparam int unsigned MAX_CYCLES    = 64;
  localparam int unsigned MAX_PERIOD    = 1000000;
  localparam int unsigned FALLBACK_ROWS = 200;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned RESET_PERIOD  = 10000;
  localparam logic [15:0] NO_SEQ        = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ROWS_VAL_W = 11;
  localparam int unsigned CYC_VAL_W  = 7;
  localparam int unsigned PER_VAL_W  = 20;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_NACK = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RS_NONE  = 3'd0,
    RS_CRC   = 3'd1,
    RS_VER   = 3'd2,
    RS_CMD   = 3'd3,
    RS_RANGE = 3'd4
  } reason_e;

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_STOP  = 2'd1,
    RUN_START = 2'd2
  } run_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC    = 3'd0,
    CFG_SCHEMA   = 3'd1,
    CFG_PING     = 3'd2,
    CFG_SETCFG   = 3'd3,
    CFG_DEFROWS  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] magic;
    logic [15:0] cmd_seq;
    logic [7:0]  schema;
    logic [7:0]  cmd_code;
    logic        crc_ok;
    logic [15:0] req_rows;
    logic [7:0]  req_cycles;
    logic [7:0]  req_source;
    logic [7:0]  req_run;
    logic [31:0] req_period;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            ack_status;
    logic [2:0]            nack_reason;
    logic                  applied_flag;
    logic [15:0]           echo_seq;
    logic                  rows_update;
    logic                  cycles_update;
    logic                  period_update;
    logic [1:0]            run_action;
    logic [ROWS_VAL_W-1:0] rows_value;
    logic [CYC_VAL_W-1:0]  cycles_value;
    logic [PER_VAL_W-1:0]  period_value;
  } res_item_t;

endpackage

### design/ccah_in_reg.sv
// ----------------------------------------------------------------------------
// ccah_in_reg
// Input stage register: holds one accepted item until the core commits it.
// ----------------------------------------------------------------------------
module ccah_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccah_pkg::in_item_t  item_i,
  input  logic                adv_i,
  output logic                valid_o,
  output ccah_pkg::in_item_t  item_o
);

  logic               valid_q, valid_d;
  ccah_pkg::in_item_t item_q;
  logic               take;

  // stage frees up in the same cycle its item moves on
  assign in_ready_o = !valid_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    priority if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### design/ccah_core.sv
// ----------------------------------------------------------------------------
// ccah_core
// Command checks, active config and status latches; builds one result per item.
// ----------------------------------------------------------------------------
module ccah_core #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccah_pkg::cfg_wr_t    cfg_i,
  input  ccah_pkg::in_item_t   item_i,
  input  logic                 adv_i,
  output ccah_pkg::res_item_t  res_o
);

  localparam int unsigned RowsCap = (MAX_ROWS > ccah_pkg::FALLBACK_ROWS) ?
                                    MAX_ROWS : ccah_pkg::FALLBACK_ROWS;
  localparam int unsigned RowsW   = $clog2(RowsCap + 1);
  localparam logic [15:0] MaxRows = 16'(MAX_ROWS);

  // configuration registers
  logic [31:0] magic_q;
  logic [7:0]  schema_q;
  logic [7:0]  ping_q;
  logic [7:0]  setcfg_q;

  // latches and active config
  ccah_pkg::status_e st_q, st_d;
  ccah_pkg::reason_e rs_q, rs_d;
  logic [15:0]       seq_q, seq_d;
  logic              oneshot_q, oneshot_d;
  logic [15:0]       last_q, last_d;
  logic              have_q, have_d;
  logic [RowsW-1:0]  rows_q, rows_d;
  logic [6:0]        cyc_q, cyc_d;
  logic              run_q, run_d;
  logic [19:0]       per_q, per_d;

  logic range_bad;

  function automatic logic [RowsW-1:0] pick_rows(input logic [10:0] r);
    logic [15:0] r16;
    r16 = 16'(r);
    if (r16 == 16'd0 || r16 > MaxRows) begin
      return RowsW'(ccah_pkg::FALLBACK_ROWS);
    end
    return RowsW'(r);
  endfunction

  assign range_bad = (item_i.req_rows == 16'd0) || (item_i.req_rows > MaxRows) ||
                     (item_i.req_cycles == 8'd0) ||
                     (item_i.req_cycles > 8'(ccah_pkg::MAX_CYCLES)) ||
                     (item_i.req_source > 8'd1) || (item_i.req_run > 8'd1) ||
                     (item_i.req_period > 32'(ccah_pkg::MAX_PERIOD));

  always_comb begin
    st_d      = st_q;
    rs_d      = rs_q;
    seq_d     = seq_q;
    oneshot_d = oneshot_q;
    last_d    = last_q;
    have_d    = have_q;
    rows_d    = rows_q;
    cyc_d     = cyc_q;
    run_d     = run_q;
    per_d     = per_q;
    res_o     = '0;

    priority if (item_i.opcode) begin
      res_o.applied_flag = oneshot_q;
      oneshot_d          = 1'b0;
    end else if (item_i.magic == magic_q) begin
      seq_d = item_i.cmd_seq;
      priority if (!item_i.crc_ok) begin
        st_d = ccah_pkg::ST_NACK;
        rs_d = ccah_pkg::RS_CRC;
      end else if (item_i.schema != schema_q) begin
        st_d = ccah_pkg::ST_NACK;
        rs_d = ccah_pkg::RS_VER;
      end else if (item_i.cmd_code == ping_q) begin
        st_d = ccah_pkg::ST_OK;
        rs_d = ccah_pkg::RS_NONE;
      end else if (item_i.cmd_code == setcfg_q) begin
        priority if (have_q && item_i.cmd_seq == last_q) begin
          // repeated sequence: acknowledge, apply nothing
          st_d = ccah_pkg::ST_OK;
          rs_d = ccah_pkg::RS_NONE;
        end else if (range_bad) begin
          st_d = ccah_pkg::ST_NACK;
          rs_d = ccah_pkg::RS_RANGE;
        end else begin
          if (item_i.req_rows != 16'(rows_q)) begin
            res_o.rows_update = 1'b1;
            res_o.rows_value  = item_i.req_rows[ccah_pkg::ROWS_VAL_W-1:0];
          end
          if (item_i.req_cycles != 8'(cyc_q)) begin
            res_o.cycles_update = 1'b1;
            res_o.cycles_value  = item_i.req_cycles[ccah_pkg::CYC_VAL_W-1:0];
          end
          if (item_i.req_period != 32'd0 && item_i.req_period != 32'(per_q)) begin
            res_o.period_update = 1'b1;
            res_o.period_value  = item_i.req_period[ccah_pkg::PER_VAL_W-1:0];
          end
          if (item_i.req_run[0] != run_q) begin
            res_o.run_action = item_i.req_run[0] ? ccah_pkg::RUN_START :
                                                   ccah_pkg::RUN_STOP;
          end
          rows_d    = RowsW'(item_i.req_rows);
          cyc_d     = item_i.req_cycles[6:0];
          run_d     = item_i.req_run[0];
          // zero period is stored, so any later nonzero value is a change
          per_d     = item_i.req_period[19:0];
          last_d    = item_i.cmd_seq;
          have_d    = 1'b1;
          st_d      = ccah_pkg::ST_OK;
          rs_d      = ccah_pkg::RS_NONE;
          oneshot_d = 1'b1;
        end
      end else begin
        st_d = ccah_pkg::ST_NACK;
        rs_d = ccah_pkg::RS_CMD;
      end
    end else begin
      // bad magic: latches stay as they are
    end

    res_o.ack_status  = st_d;
    res_o.nack_reason = rs_d;
    res_o.echo_seq    = seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      schema_q  <= 8'd1;
      ping_q    <= 8'd0;
      setcfg_q  <= 8'd1;
      st_q      <= ccah_pkg::ST_NONE;
      rs_q      <= ccah_pkg::RS_NONE;
      seq_q     <= '0;
      oneshot_q <= 1'b0;
      last_q    <= ccah_pkg::NO_SEQ;
      have_q    <= 1'b0;
      rows_q    <= RowsW'(ccah_pkg::FALLBACK_ROWS);
      cyc_q     <= 7'(ccah_pkg::RESET_CYCLES);
      run_q     <= 1'b1;
      per_q     <= 20'(ccah_pkg::RESET_PERIOD);
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          ccah_pkg::CFG_MAGIC:   magic_q  <= cfg_i.data;
          ccah_pkg::CFG_SCHEMA:  schema_q <= cfg_i.data[7:0];
          ccah_pkg::CFG_PING:    ping_q   <= cfg_i.data[7:0];
          ccah_pkg::CFG_SETCFG:  setcfg_q <= cfg_i.data[7:0];
          default: ;
        endcase
      end
      if (adv_i) begin
        st_d_commit: begin
          st_q      <= st_d;
          rs_q      <= rs_d;
          seq_q     <= seq_d;
          oneshot_q <= oneshot_d;
          last_q    <= last_d;
          have_q    <= have_d;
          cyc_q     <= cyc_d;
          run_q     <= run_d;
          per_q     <= per_d;
        end
      end
      // a default_rows write also reloads the active rows
      priority if (cfg_i.we && cfg_i.idx == ccah_pkg::CFG_DEFROWS) begin
        rows_q <= pick_rows(cfg_i.data[10:0]);
      end else if (adv_i) begin
        rows_q <= rows_d;
      end
    end
  end

  a_frame_clears_oneshot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.opcode |=> !oneshot_q
  ) else $error("one-shot applied bit survived a frame item");

  a_have_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    have_q |=> have_q
  ) else $error("have_applied dropped");

  a_strobe_means_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv_i && (res_o.rows_update || res_o.cycles_update || res_o.period_update)
      |=> oneshot_q && st_q == ccah_pkg::ST_OK && have_q
  ) else $error("update strobe without an applied set-config");

endmodule

### design/ccah_out_reg.sv
// ----------------------------------------------------------------------------
// ccah_out_reg
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module ccah_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 src_valid_i,
  output logic                 adv_o,
  input  ccah_pkg::res_item_t  res_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ccah_pkg::res_item_t  res_o
);

  logic                valid_q, valid_d;
  ccah_pkg::res_item_t res_q;

  // load whenever the register is empty or being emptied
  assign adv_o = src_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    priority if (adv_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/config_command_ack_handler_top.sv
// ----------------------------------------------------------------------------
// config_command_ack_handler_top
// Command acknowledge handler: checks parsed commands, keeps the active
// config and sticky ACK/NACK status, and reports status on frame items.
//
//   channel   dir   handshake                 payload
//   in        in    in_valid_i / in_ready_o   opcode_i .. req_period_i
//   out       out   out_valid_o / out_ready_i ack_status_o .. period_value_o
//   cfg       in    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while out_ready_i holds high; an accepted item
// passes the input register, then its result is loaded into the result register
// the rate is set by the single check stage that reads and writes the
// latches and active config in the same cycle
// reset loads all latches and active config at once, no sweep
// a stalled result holds in the result register; one more item is taken
// into the input register, then in_ready_o drops until out_ready_i returns
// ----------------------------------------------------------------------------
module config_command_ack_handler_top #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_we_i,
  input  logic [ccah_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccah_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [31:0]                     magic_i,
  input  logic [15:0]                     cmd_seq_i,
  input  logic [7:0]                      schema_i,
  input  logic [7:0]                      cmd_code_i,
  input  logic                            crc_ok_i,
  input  logic [15:0]                     req_rows_i,
  input  logic [7:0]                      req_cycles_i,
  input  logic [7:0]                      req_source_i,
  input  logic [7:0]                      req_run_i,
  input  logic [31:0]                     req_period_i,

  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      ack_status_o,
  output logic [2:0]                      nack_reason_o,
  output logic                            applied_flag_o,
  output logic [15:0]                     echo_seq_o,
  output logic                            rows_update_o,
  output logic                            cycles_update_o,
  output logic                            period_update_o,
  output logic [1:0]                      run_action_o,
  output logic [ccah_pkg::ROWS_VAL_W-1:0] rows_value_o,
  output logic [ccah_pkg::CYC_VAL_W-1:0]  cycles_value_o,
  output logic [ccah_pkg::PER_VAL_W-1:0]  period_value_o
);

  ccah_pkg::cfg_wr_t   cfg;
  ccah_pkg::in_item_t  in_item;
  ccah_pkg::in_item_t  s1_item;
  ccah_pkg::res_item_t core_res;
  ccah_pkg::res_item_t out_res;
  logic                s1_valid;
  logic                adv;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign in_item.opcode     = opcode_i;
  assign in_item.magic      = magic_i;
  assign in_item.cmd_seq    = cmd_seq_i;
  assign in_item.schema     = schema_i;
  assign in_item.cmd_code   = cmd_code_i;
  assign in_item.crc_ok     = crc_ok_i;
  assign in_item.req_rows   = req_rows_i;
  assign in_item.req_cycles = req_cycles_i;
  assign in_item.req_source = req_source_i;
  assign in_item.req_run    = req_run_i;
  assign in_item.req_period = req_period_i;

  ccah_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ccah_core #(
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (s1_item),
    .adv_i  (adv),
    .res_o  (core_res)
  );

  ccah_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (s1_valid),
    .adv_o       (adv),
    .res_i       (core_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign ack_status_o    = out_res.ack_status;
  assign nack_reason_o   = out_res.nack_reason;
  assign applied_flag_o  = out_res.applied_flag;
  assign echo_seq_o      = out_res.echo_seq;
  assign rows_update_o   = out_res.rows_update;
  assign cycles_update_o = out_res.cycles_update;
  assign period_update_o = out_res.period_update;
  assign run_action_o    = out_res.run_action;
  assign rows_value_o    = out_res.rows_value;
  assign cycles_value_o  = out_res.cycles_value;
  assign period_value_o  = out_res.period_value;

  a_frame_no_strobes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && applied_flag_o |->
      !rows_update_o && !cycles_update_o && !period_update_o &&
      run_action_o == ccah_pkg::RUN_NONE
  ) else $error("frame result carries an update");

  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with an empty result register");

endmodule

### sim/ack_handler_checker.sv
// ----------------------------------------------------------------------------
// ack_handler_checker
// Watches the config, command and result ports of the command acknowledge
// handler. It keeps its own copy of the registers, the latches and the active
// config, predicts the result of every accepted item and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ack_handler_checker #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccah_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccah_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  ccah_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  ccah_pkg::res_item_t             res_item_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     results_o
);

  // register copies
  logic [31:0] magic_word;
  logic [7:0]  schema_want;
  logic [7:0]  ping_cmd;
  logic [7:0]  setcfg_cmd;
  logic [10:0] rows_default;

  // latches and active config
  ccah_pkg::status_e ack_state;
  ccah_pkg::reason_e reason_state;
  logic [15:0]       echoed_seq;
  logic              applied_pending;
  logic [15:0]       prev_applied_seq;
  logic              seq_valid;
  logic [10:0]       cur_rows;
  logic [6:0]        cur_cycles;
  logic              cur_running;
  logic [19:0]       cur_period;

  ccah_pkg::res_item_t expected_acks[$];

  function automatic ccah_pkg::res_item_t predict_ack_result(input ccah_pkg::in_item_t it);
    ccah_pkg::res_item_t r;
    r = '0;
    if (it.opcode) begin
      r.applied_flag  = applied_pending;
      applied_pending = 1'b0;
    end else if (it.magic == magic_word) begin
      echoed_seq = it.cmd_seq;
      if (!it.crc_ok) begin
        ack_state    = ccah_pkg::ST_NACK;
        reason_state = ccah_pkg::RS_CRC;
      end else if (it.schema != schema_want) begin
        ack_state    = ccah_pkg::ST_NACK;
        reason_state = ccah_pkg::RS_VER;
      end else if (it.cmd_code == ping_cmd) begin
        ack_state    = ccah_pkg::ST_OK;
        reason_state = ccah_pkg::RS_NONE;
      end else if (it.cmd_code == setcfg_cmd) begin
        if (seq_valid && it.cmd_seq == prev_applied_seq) begin
          // repeated command: ack again, apply nothing
          ack_state    = ccah_pkg::ST_OK;
          reason_state = ccah_pkg::RS_NONE;
        end else if (it.req_rows == 0 || it.req_rows > MAX_ROWS ||
                     it.req_cycles == 0 || it.req_cycles > ccah_pkg::MAX_CYCLES ||
                     it.req_source > 1 || it.req_run > 1 ||
                     it.req_period > ccah_pkg::MAX_PERIOD) begin
          ack_state    = ccah_pkg::ST_NACK;
          reason_state = ccah_pkg::RS_RANGE;
        end else begin
          if (it.req_rows != cur_rows) begin
            r.rows_update = 1'b1;
            r.rows_value  = it.req_rows[10:0];
          end
          if (it.req_cycles != cur_cycles) begin
            r.cycles_update = 1'b1;
            r.cycles_value  = it.req_cycles[6:0];
          end
          // period zero leaves the output alone but still clears the active copy
          if (it.req_period != 0 && it.req_period != cur_period) begin
            r.period_update = 1'b1;
            r.period_value  = it.req_period[19:0];
          end
          if (it.req_run[0] != cur_running) begin
            r.run_action = it.req_run[0] ? ccah_pkg::RUN_START : ccah_pkg::RUN_STOP;
          end
          cur_rows         = it.req_rows[10:0];
          cur_cycles       = it.req_cycles[6:0];
          cur_running      = it.req_run[0];
          cur_period       = it.req_period[19:0];
          prev_applied_seq = it.cmd_seq;
          seq_valid        = 1'b1;
          ack_state        = ccah_pkg::ST_OK;
          reason_state     = ccah_pkg::RS_NONE;
          applied_pending  = 1'b1;
        end
      end else begin
        ack_state    = ccah_pkg::ST_NACK;
        reason_state = ccah_pkg::RS_CMD;
      end
    end
    r.ack_status  = ack_state;
    r.nack_reason = reason_state;
    r.echo_seq    = echoed_seq;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ccah_pkg::res_item_t want;
    if (!rst_ni) begin
      magic_word       = '0;
      schema_want      = 8'd1;
      ping_cmd         = 8'd0;
      setcfg_cmd       = 8'd1;
      rows_default     = 11'(ccah_pkg::FALLBACK_ROWS);
      ack_state        = ccah_pkg::ST_NONE;
      reason_state     = ccah_pkg::RS_NONE;
      echoed_seq       = '0;
      applied_pending  = 1'b0;
      prev_applied_seq = ccah_pkg::NO_SEQ;
      seq_valid        = 1'b0;
      cur_rows         = 11'(ccah_pkg::FALLBACK_ROWS);
      cur_cycles       = 7'(ccah_pkg::RESET_CYCLES);
      cur_running      = 1'b1;
      cur_period       = 20'(ccah_pkg::RESET_PERIOD);
      expected_acks.delete();
      mismatches_o     = 0;
      pending_o        = 0;
      results_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_acks.size() == 0) begin
          $error("result item arrived with no command or frame item pending");
          mismatches_o++;
        end else begin
          want = expected_acks.pop_front();
          check_field("ack_status", 32'(want.ack_status), 32'(res_item_i.ack_status));
          check_field("nack_reason", 32'(want.nack_reason), 32'(res_item_i.nack_reason));
          check_field("applied_flag", 32'(want.applied_flag),
                      32'(res_item_i.applied_flag));
          check_field("echo_seq", 32'(want.echo_seq), 32'(res_item_i.echo_seq));
          check_field("rows_update", 32'(want.rows_update), 32'(res_item_i.rows_update));
          check_field("cycles_update", 32'(want.cycles_update),
                      32'(res_item_i.cycles_update));
          check_field("period_update", 32'(want.period_update),
                      32'(res_item_i.period_update));
          check_field("run_action", 32'(want.run_action), 32'(res_item_i.run_action));
          check_field("rows_value", 32'(want.rows_value), 32'(res_item_i.rows_value));
          check_field("cycles_value", 32'(want.cycles_value),
                      32'(res_item_i.cycles_value));
          check_field("period_value", 32'(want.period_value),
                      32'(res_item_i.period_value));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_acks.push_back(predict_ack_result(in_item_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ccah_pkg::CFG_MAGIC:   magic_word  = cfg_data_i;
          ccah_pkg::CFG_SCHEMA:  schema_want = cfg_data_i[7:0];
          ccah_pkg::CFG_PING:    ping_cmd    = cfg_data_i[7:0];
          ccah_pkg::CFG_SETCFG:  setcfg_cmd  = cfg_data_i[7:0];
          ccah_pkg::CFG_DEFROWS: begin
            rows_default = cfg_data_i[10:0];
            // writing the default also reloads the active rows
            cur_rows = (rows_default == 0 || rows_default > MAX_ROWS) ?
                       11'(ccah_pkg::FALLBACK_ROWS) : rows_default;
          end
          default: ;
        endcase
      end
      pending_o = expected_acks.size();
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the command acknowledge handler with a directed set of commands and
// frame items, then random traffic under three handshake patterns and several
// register settings. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_ROWS         = 1024;
  localparam int unsigned RANDOM_PER_PHASE = 660;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic clk = 1'b0;
  logic rst_n;

  logic                            cfg_we;
  logic [ccah_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ccah_pkg::CFG_DATA_W-1:0] cfg_data;

  logic               in_valid;
  logic               in_ready;
  ccah_pkg::in_item_t in_bus;

  logic                out_valid;
  logic                out_ready;
  ccah_pkg::res_item_t res_bus;

  logic [1:0]                      ack_status;
  logic [2:0]                      nack_reason;
  logic                            applied_flag;
  logic [15:0]                     echo_seq;
  logic                            rows_update;
  logic                            cycles_update;
  logic                            period_update;
  logic [1:0]                      run_action;
  logic [ccah_pkg::ROWS_VAL_W-1:0] rows_value;
  logic [ccah_pkg::CYC_VAL_W-1:0]  cycles_value;
  logic [ccah_pkg::PER_VAL_W-1:0]  period_value;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned settings_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // stimulus view of the registers
  logic [31:0] cur_magic;
  logic [7:0]  cur_schema;
  logic [7:0]  cur_ping;
  logic [7:0]  cur_setcfg;
  logic [15:0] last_seq = '0;

  assign res_bus = {ack_status, nack_reason, applied_flag, echo_seq, rows_update,
                    cycles_update, period_update, run_action, rows_value,
                    cycles_value, period_value};

  config_command_ack_handler_top #(
    .MAX_ROWS (MAX_ROWS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (in_bus.opcode),
    .magic_i         (in_bus.magic),
    .cmd_seq_i       (in_bus.cmd_seq),
    .schema_i        (in_bus.schema),
    .cmd_code_i      (in_bus.cmd_code),
    .crc_ok_i        (in_bus.crc_ok),
    .req_rows_i      (in_bus.req_rows),
    .req_cycles_i    (in_bus.req_cycles),
    .req_source_i    (in_bus.req_source),
    .req_run_i       (in_bus.req_run),
    .req_period_i    (in_bus.req_period),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .ack_status_o    (ack_status),
    .nack_reason_o   (nack_reason),
    .applied_flag_o  (applied_flag),
    .echo_seq_o      (echo_seq),
    .rows_update_o   (rows_update),
    .cycles_update_o (cycles_update),
    .period_update_o (period_update),
    .run_action_o    (run_action),
    .rows_value_o    (rows_value),
    .cycles_value_o  (cycles_value),
    .period_value_o  (period_value)
  );

  ack_handler_checker #(
    .MAX_ROWS (MAX_ROWS)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_bus),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .res_item_i   (res_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input ccah_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_bus   <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (!it.opcode) last_seq = it.cmd_seq;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ccah_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] magic, input logic [7:0] schema,
                                input logic [7:0] ping, input logic [7:0] setcfg,
                                input logic [10:0] defrows);
    wait_drained();
    write_reg(ccah_pkg::CFG_MAGIC, magic);
    write_reg(ccah_pkg::CFG_SCHEMA, {24'($urandom()), schema});
    write_reg(ccah_pkg::CFG_PING, {24'($urandom()), ping});
    write_reg(ccah_pkg::CFG_SETCFG, {24'($urandom()), setcfg});
    write_reg(ccah_pkg::CFG_DEFROWS, {21'($urandom()), defrows});
    // unused index must change nothing
    write_reg(ccah_pkg::CFG_IDX_W'(ccah_pkg::CFG_DEFROWS + $urandom_range(1, 3)),
              $urandom());
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_magic  = magic;
    cur_schema = schema;
    cur_ping   = ping;
    cur_setcfg = setcfg;
    settings_count++;
  endtask

  function automatic ccah_pkg::in_item_t good_setcfg(input logic [15:0] seq,
                                                     input logic [15:0] rows,
                                                     input logic [7:0] cycles,
                                                     input logic [7:0] run,
                                                     input logic [31:0] period);
    ccah_pkg::in_item_t it;
    it            = '0;
    it.magic      = cur_magic;
    it.cmd_seq    = seq;
    it.schema     = cur_schema;
    it.cmd_code   = cur_setcfg;
    it.crc_ok     = 1'b1;
    it.req_rows   = rows;
    it.req_cycles = cycles;
    it.req_run    = run;
    it.req_period = period;
    return it;
  endfunction

  function automatic ccah_pkg::in_item_t random_item();
    ccah_pkg::in_item_t it;
    int unsigned        pick;
    it.opcode     = ($urandom_range(99) < 30);
    it.magic      = ($urandom_range(99) < 90) ? cur_magic : $urandom();
    it.cmd_seq    = ($urandom_range(99) < 20) ? last_seq : 16'($urandom());
    it.schema     = ($urandom_range(99) < 92) ? cur_schema : 8'($urandom());
    pick          = $urandom_range(99);
    it.cmd_code   = (pick < 50) ? cur_setcfg : (pick < 75) ? cur_ping : 8'($urandom());
    it.crc_ok     = ($urandom_range(99) < 92);
    pick          = $urandom_range(99);
    it.req_rows   = (pick < 10) ? 16'd1 : (pick < 20) ? 16'(MAX_ROWS) :
                    (pick < 35) ? 16'(ccah_pkg::FALLBACK_ROWS) :
                    (pick < 95) ? 16'($urandom_range(1, MAX_ROWS)) : 16'($urandom());
    pick          = $urandom_range(99);
    it.req_cycles = (pick < 10) ? 8'd1 : (pick < 20) ? 8'(ccah_pkg::MAX_CYCLES) :
                    (pick < 35) ? 8'(ccah_pkg::RESET_CYCLES) :
                    (pick < 95) ? 8'($urandom_range(1, ccah_pkg::MAX_CYCLES)) :
                                  8'($urandom());
    it.req_source = ($urandom_range(99) < 95) ? 8'($urandom_range(0, 1)) : 8'($urandom());
    it.req_run    = ($urandom_range(99) < 95) ? 8'($urandom_range(0, 1)) : 8'($urandom());
    pick          = $urandom_range(99);
    it.req_period = (pick < 20) ? 32'd0 : (pick < 30) ? 32'(ccah_pkg::MAX_PERIOD) :
                    (pick < 40) ? 32'(ccah_pkg::RESET_PERIOD) :
                    (pick < 95) ? 32'($urandom_range(1, ccah_pkg::MAX_PERIOD)) :
                                  $urandom();
    return it;
  endfunction

  task automatic run_directed();
    ccah_pkg::in_item_t it;
    logic [7:0]         other_code;
    other_code = 8'd1;
    while (other_code == cur_ping || other_code == cur_setcfg) other_code++;

    it = good_setcfg(16'h1234, 16'd8, 8'd8, 8'd1, 32'd500);
    it.opcode = 1'b1;
    send_item(it);                               // frame before any command
    it = good_setcfg(16'h0001, 16'd8, 8'd8, 8'd1, 32'd500);
    it.magic = ~cur_magic;
    send_item(it);                               // wrong magic, ignored
    it = good_setcfg(16'h0002, 16'd8, 8'd8, 8'd1, 32'd500);
    it.crc_ok = 1'b0;
    send_item(it);
    it = good_setcfg(16'h0003, 16'd8, 8'd8, 8'd1, 32'd500);
    it.schema = ~cur_schema;
    send_item(it);
    it = good_setcfg(16'h0004, 16'd8, 8'd8, 8'd1, 32'd500);
    it.cmd_code = cur_ping;
    send_item(it);
    it = good_setcfg(16'h0005, 16'd8, 8'd8, 8'd1, 32'd500);
    it.cmd_code = other_code;
    send_item(it);
    // first apply uses the all-ones sequence, which must not look repeated
    send_item(good_setcfg(16'hFFFF, 16'(MAX_ROWS), 8'(ccah_pkg::MAX_CYCLES), 8'd0,
                          32'(ccah_pkg::MAX_PERIOD)));
    it = good_setcfg(16'h0, 16'd0, 8'd0, 8'd0, 32'd0);
    it.opcode = 1'b1;
    send_item(it);                               // one-shot set
    send_item(it);                               // one-shot cleared
    send_item(good_setcfg(16'hFFFF, 16'd1, 8'd1, 8'd1, 32'd1));   // repeated sequence
    send_item(good_setcfg(16'h0010, 16'd0, 8'd4, 8'd1, 32'd1));
    send_item(good_setcfg(16'h0011, 16'hFFFF, 8'd4, 8'd1, 32'd1));
    send_item(good_setcfg(16'h0012, 16'd2, 8'd0, 8'd1, 32'd1));
    send_item(good_setcfg(16'h0013, 16'd2, 8'(ccah_pkg::MAX_CYCLES + 1), 8'd1, 32'd1));
    send_item(good_setcfg(16'h0014, 16'd2, 8'hFF, 8'd1, 32'd1));
    it = good_setcfg(16'h0015, 16'd2, 8'd4, 8'd1, 32'd1);
    it.req_source = 8'hFF;
    send_item(it);
    send_item(good_setcfg(16'h0016, 16'd2, 8'd4, 8'hFF, 32'd1));
    send_item(good_setcfg(16'h0017, 16'd2, 8'd4, 8'd1, 32'(ccah_pkg::MAX_PERIOD + 1)));
    send_item(good_setcfg(16'h0018, 16'd2, 8'd4, 8'd1, 32'hFFFF_FFFF));
    send_item(good_setcfg(16'h0020, 16'd1, 8'd1, 8'd1, 32'd0));       // period left alone
    send_item(good_setcfg(16'h0021, 16'd1, 8'd1, 8'd1, 32'(ccah_pkg::RESET_PERIOD)));
    send_item(good_setcfg(16'h0022, 16'd1, 8'd1, 8'd1, 32'(ccah_pkg::RESET_PERIOD)));
    it.opcode = 1'b1;
    send_item(it);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_bus    = '0;
    send_idle_pct = 27;
    recv_idle_pct = 53;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    apply_settings(32'hFFFF_FFFF, 8'd0, 8'd255, 8'd0, 11'd1);
    run_directed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 27;
          apply_settings(32'h0, 8'd255, 8'd0, 8'd255, 11'h7FF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          apply_settings($urandom(), 8'd1, 8'd0, 8'd1, 11'(MAX_ROWS));
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // mid-phase: let every result come back, then pick new random settings
        if (n == RANDOM_PER_PHASE / 2) begin
          apply_settings($urandom(), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                         ($urandom_range(3) == 0) ? 11'd0 : 11'($urandom()));
        end
        send_item(random_item());
      end
    end

    wait_drained();
    $display("sent %0d items (commands, frames, bad magic, nack and apply paths)",
             items_sent);
    $display("checked %0d results over %0d register settings and three handshake patterns",
             results, settings_count);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
